### rtl/tkw_pkg.sv
`default_nettype none

package tkw_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int WORD_CHARS_DEF  = 48;

	typedef enum logic [1:0] {
		OP_OFFER = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] char_code;
		logic [30:0] word_score;
		logic        last_char;
		logic [3:0]  entry_index;
		logic [5:0]  char_position;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [3:0]  insert_position;
		logic [15:0] read_char;
		logic [30:0] read_score;
		logic [4:0]  entry_count;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/tkw_ram.sv
`default_nettype none

module tkw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 816
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/top_k_scored_word_insert.sv
// Offer of a non-final character: no result transfer. Offer of a final character: accepted,
// then one score compare per cycle until a place is found or the last rank is compared, then
// the result is loaded; a word rejected as too long goes straight to the result.
// Read: capture, table and word RAM read, result. Clear: capture, result.
// One request is in work at a time; the next is taken once its result sits in the output
// register. Asynchronous reset clears scores, lengths and slot map; the word RAM is not cleared.
`default_nettype none

module top_k_scored_word_insert #(
	parameter int NUM_ENTRIES = tkw_pkg::NUM_ENTRIES_DEF,
	parameter int WORD_CHARS  = tkw_pkg::WORD_CHARS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tkw_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tkw_pkg::rsp_t      rsp
);

	import tkw_pkg::*;

	// Rank index, physical slot, stored length and word RAM address widths.
	localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int SLOT_W = $clog2(NUM_ENTRIES + 1);
	localparam int LEN_W  = $clog2(WORD_CHARS + 1);
	localparam int POS_W  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
	localparam int DEPTH  = (NUM_ENTRIES + 1) * WORD_CHARS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);

	// The word RAM holds NUM_ENTRIES + 1 word slots. The ranked table refers to
	// its words through a slot map, so an insert moves slot numbers rather than
	// characters. The one slot that no rank refers to is the spare: the word
	// being offered is written straight into it, character by character. When
	// the word is inserted the spare joins the map and the slot of the dropped
	// last rank becomes the new spare; when it is rejected nothing is lost.

	state_t state_q, state_d;

	logic [30:0]       score_q [NUM_ENTRIES];
	logic [LEN_W-1:0]  len_q   [NUM_ENTRIES];
	logic [SLOT_W-1:0] map_q   [NUM_ENTRIES];
	logic [SLOT_W-1:0] spare_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  staging_len_q;
	logic              too_long_q;

	// Request fields held for the multi-cycle operations.
	logic [30:0]       new_score_q;
	logic [IDX_W-1:0]  scan_ptr_q;
	logic [IDX_W-1:0]  rd_rank_q;
	logic              rd_in_range_q;
	logic [5:0]        rd_pos_q;

	// Result fields, assembled into the output register in the final state.
	logic              acc_q;
	logic [IDX_W-1:0]  at_q;
	logic [30:0]       rs_q;
	logic              hit_q;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              req_xfer;
	logic              full;
	logic              reject;
	logic              rd_in_range;
	logic [IDX_W-1:0]  rank_a;
	logic [30:0]       score_a;
	logic [LEN_W-1:0]  len_a;
	logic [SLOT_W-1:0] map_a;
	logic              beats;
	logic              last_rank;
	logic              pos_ok;
	logic [POS_W-1:0]  rd_off;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;
	logic              rsp_load;
	rsp_t              rsp_d;

	assign req_xfer    = req_valid && !req_stall;
	assign full        = (staging_len_q == LEN_W'(WORD_CHARS));
	// A final character that finds the staging word full rejects the word.
	assign reject      = too_long_q || full;
	assign rd_in_range = (int'(req.entry_index) < NUM_ENTRIES);

	// One table read port, shared by the score scan and the entry read.
	assign rank_a  = (state_q == ST_SCAN) ? scan_ptr_q : rd_rank_q;
	assign score_a = score_q[rank_a];
	assign len_a   = len_q[rank_a];
	assign map_a   = map_q[rank_a];

	// The shared comparator: does the new word beat the entry at the scan pointer?
	assign beats     = (new_score_q > score_a);
	assign last_rank = (scan_ptr_q == IDX_W'(NUM_ENTRIES - 1));

	assign pos_ok = (int'(rd_pos_q) < int'(len_a));
	assign rd_off = pos_ok ? POS_W'(rd_pos_q) : '0;

	assign ram_waddr = ADDR_W'(ADDR_W'(spare_q) * ADDR_W'(WORD_CHARS)
		+ ADDR_W'(staging_len_q));
	assign ram_raddr = ADDR_W'(ADDR_W'(map_a) * ADDR_W'(WORD_CHARS) + ADDR_W'(rd_off));

	tkw_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_word_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.char_code),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, request stall and RAM strobes.
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (req.operation)
						OP_OFFER: begin
							ram_we = !full;
							if (req.last_char) begin
								state_d = reject ? ST_DONE : ST_SCAN;
							end
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						OP_CLEAR: begin
							state_d = ST_DONE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (beats || last_rank) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				rsp_load = !rsp_valid_q || !rsp_stall;
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Table state: scores, lengths, slot map, spare slot, count and staging word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				score_q[i] <= '0;
				len_q[i]   <= '0;
				map_q[i]   <= SLOT_W'(i);
			end
			spare_q       <= SLOT_W'(NUM_ENTRIES);
			count_q       <= '0;
			staging_len_q <= '0;
			too_long_q    <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && req_xfer) begin
				case (req.operation)
					OP_OFFER: begin
						// A rejected word empties the staging word at once.
						if (req.last_char && reject) begin
							staging_len_q <= '0;
							too_long_q    <= 1'b0;
						end else if (full) begin
							too_long_q <= 1'b1;
						end else begin
							staging_len_q <= staging_len_q + LEN_W'(1);
						end
					end
					OP_CLEAR: begin
						for (int i = 0; i < NUM_ENTRIES; i++) begin
							score_q[i] <= '0;
							len_q[i]   <= '0;
						end
						count_q       <= '0;
						staging_len_q <= '0;
						too_long_q    <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_SCAN) begin
				if (beats) begin
					// Every rank below the place takes its upper neighbour's entry.
					for (int j = 1; j < NUM_ENTRIES; j++) begin
						if (IDX_W'(j) > scan_ptr_q) begin
							score_q[j] <= score_q[j-1];
							len_q[j]   <= len_q[j-1];
							map_q[j]   <= map_q[j-1];
						end
					end
					score_q[scan_ptr_q] <= new_score_q;
					len_q[scan_ptr_q]   <= staging_len_q;
					map_q[scan_ptr_q]   <= spare_q;
					spare_q             <= map_q[NUM_ENTRIES-1];
					if (count_q != CNT_W'(NUM_ENTRIES)) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				if (beats || last_rank) begin
					staging_len_q <= '0;
					too_long_q    <= 1'b0;
				end
			end
		end
	end

	// Held request fields and result fields.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_xfer) begin
			new_score_q   <= req.word_score;
			scan_ptr_q    <= '0;
			rd_in_range_q <= rd_in_range;
			rd_rank_q     <= rd_in_range ? IDX_W'(req.entry_index) : '0;
			rd_pos_q      <= req.char_position;
			acc_q         <= 1'b0;
			at_q          <= '0;
			rs_q          <= '0;
			hit_q         <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (beats) begin
				acc_q <= 1'b1;
				at_q  <= scan_ptr_q;
			end else if (!last_rank) begin
				scan_ptr_q <= scan_ptr_q + IDX_W'(1);
			end
		end
		if (state_q == ST_READ) begin
			rs_q  <= rd_in_range_q ? score_a : '0;
			hit_q <= rd_in_range_q && pos_ok;
		end
	end

	always_comb begin
		rsp_d.accepted        = acc_q;
		rsp_d.insert_position = 4'(at_q);
		rsp_d.read_char       = hit_q ? ram_rdata : '0;
		rsp_d.read_score      = rs_q;
		rsp_d.entry_count     = 5'(count_q);
	end

	// Output register: a waiting result holds until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The scores must stay in descending order.
	logic sorted_ok;
	always_comb begin
		sorted_ok = 1'b1;
		for (int j = 1; j < NUM_ENTRIES; j++) begin
			if (score_q[j] > score_q[j-1]) begin
				sorted_ok = 1'b0;
			end
		end
	end

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n) sorted_ok)
		else $error("score table out of order");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_ENTRIES))
		else $error("entry count beyond table size");

	a_staging_range: assert property (@(posedge clk) disable iff (!arst_n)
		staging_len_q <= LEN_W'(WORD_CHARS))
		else $error("staging length beyond word store");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && acc_q) |-> count_q != '0)
		else $error("accepted word but table empty");

endmodule

`default_nettype wire

### bench/word_rank_checker.sv
`default_nettype none

module word_rank_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_stall,
	input  wire tkw_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire tkw_pkg::rsp_t rsp,
	output int                 outstanding,
	output int                 mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	import tkw_pkg::*;

	localparam int ENTRIES = NUM_ENTRIES_DEF;
	localparam int CHARS   = WORD_CHARS_DEF;

	// Predicted contents of the ranked table and of the word being assembled.
	logic [30:0] rank_score [ENTRIES];
	logic [15:0] rank_text [ENTRIES][CHARS];
	int unsigned rank_len [ENTRIES];
	logic [15:0] draft_text [CHARS];
	int unsigned draft_len;
	bit          draft_overflow;

	rsp_t expected_q [$];
	rsp_t oldest;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic logic [4:0] live_entries();
		int n;
		n = 0;
		while (n < ENTRIES && rank_score[n] != '0)
			n++;
		return n[4:0];
	endfunction

	task automatic predict_transfer(input req_t r);
		rsp_t want;
		int   slot;
		want = '0;
		case (r.operation)
			OP_OFFER: begin
				if (draft_len < CHARS) begin
					draft_text[draft_len] = r.char_code;
					draft_len++;
				end else begin
					draft_overflow = 1'b1;
				end
				if (r.last_char) begin
					if (!draft_overflow) begin
						// The new word goes in front of the first strictly lower score.
						slot = 0;
						while (slot < ENTRIES && r.word_score <= rank_score[slot])
							slot++;
						if (slot < ENTRIES) begin
							for (int j = ENTRIES - 1; j > slot; j--) begin
								rank_score[j] = rank_score[j - 1];
								rank_len[j]   = rank_len[j - 1];
								for (int k = 0; k < CHARS; k++)
									rank_text[j][k] = rank_text[j - 1][k];
							end
							rank_score[slot] = r.word_score;
							rank_len[slot]   = draft_len;
							for (int k = 0; k < draft_len; k++)
								rank_text[slot][k] = draft_text[k];
							want.accepted        = 1'b1;
							want.insert_position = slot[3:0];
						end
					end
					draft_len         = 0;
					draft_overflow    = 1'b0;
					want.entry_count  = live_entries();
					expected_q.push_back(want);
				end
			end
			OP_READ: begin
				if (r.entry_index < ENTRIES) begin
					want.read_score = rank_score[r.entry_index];
					if (r.char_position < rank_len[r.entry_index] && r.char_position < CHARS)
						want.read_char = rank_text[r.entry_index][r.char_position];
				end
				want.entry_count = live_entries();
				expected_q.push_back(want);
			end
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) begin
					rank_score[i] = '0;
					rank_len[i]   = 0;
				end
				draft_len      = 0;
				draft_overflow = 1'b0;
				expected_q.push_back(want);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_score[i] = '0;
				rank_len[i]   = 0;
			end
			draft_len      = 0;
			draft_overflow = 1'b0;
			expected_q.delete();
			mismatches     = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result transfer with no result expected");
				end else begin
					oldest = expected_q.pop_front();
					check_field("accepted", rsp.accepted, oldest.accepted);
					check_field("insert_position", rsp.insert_position, oldest.insert_position);
					check_field("read_char", rsp.read_char, oldest.read_char);
					check_field("read_score", rsp.read_score, oldest.read_score);
					check_field("entry_count", rsp.entry_count, oldest.entry_count);
				end
			end
			if (req_valid && !req_stall)
				predict_transfer(req);
			outstanding <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

### bench/top_k_scored_word_insert_tb.sv
`default_nettype none

module top_k_scored_word_insert_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tkw_pkg::*;

	// The package names only three operations; the fourth encoding must be ignored.
	localparam op_t OP_UNUSED    = op_t'(2'd3);
	localparam int  ITEM_TARGET   = 1750;
	// An insert scans at most sixteen ranks, so reaching this limit without any
	// transfer on either channel can only mean the block has hung.
	localparam int  QUIET_LIMIT   = 4000;
	localparam int  SETTLE_CYCLES = 40;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int outstanding;
	int mismatches;

	// Idling pressure on each side, in percent of cycles.
	int send_idle_pct  = 38;
	int recv_stall_pct = 88;
	int phase          = 0;
	int items_sent     = 0;
	int quiet_cycles   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	top_k_scored_word_insert i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	word_rank_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	// The receiving side stalls at random, independently of what is on offer.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: any transfer on either channel resets the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Every field but the operation is random, so that the fields an operation does
	// not use are shown to be ignored. Callers overwrite the fields that matter.
	function automatic req_t scrambled_req();
		req_t r;
		r.operation     = OP_READ;
		r.char_code     = 16'($urandom_range(65535));
		r.word_score    = 31'($urandom());
		r.last_char     = 1'($urandom_range(1));
		r.entry_index   = 4'($urandom_range(15));
		r.char_position = 6'($urandom_range(47));
		return r;
	endfunction

	// Scores are biased towards a handful of small values so that ties and a
	// full table with no place left turn up often, with zero and the largest
	// score mixed in.
	function automatic logic [30:0] pick_score();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 31'($urandom_range(8, 1));
		if (pick < 50)
			return '0;
		if (pick < 60)
			return '1;
		return 31'($urandom());
	endfunction

	// Mostly short words, with the full length and a few words that overflow
	// the store mixed in.
	function automatic int pick_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return $urandom_range(6, 1);
		if (pick < 85)
			return $urandom_range(20, 7);
		if (pick < 93)
			return $urandom_range(47, 21);
		if (pick < 97)
			return WORD_CHARS_DEF;
		return $urandom_range(WORD_CHARS_DEF + 4, WORD_CHARS_DEF + 1);
	endfunction

	// One request transfer. Valid is held high from one item to the next unless
	// the sender chooses to idle, and the payload stays put while stalled.
	task automatic send(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		if (r.operation != OP_UNUSED)
			items_sent++;
	endtask

	// The sender stops and waits until every expected result has been taken.
	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic offer_char(input logic [15:0] ch, input logic [30:0] score, input bit last);
		req_t r;
		r            = scrambled_req();
		r.operation  = OP_OFFER;
		r.char_code  = ch;
		r.word_score = score;
		r.last_char  = last;
		send(r);
	endtask

	task automatic read_entry(input logic [3:0] idx, input logic [5:0] pos);
		req_t r;
		r               = scrambled_req();
		r.operation     = OP_READ;
		r.entry_index   = idx;
		r.char_position = pos;
		send(r);
	endtask

	task automatic clear_table();
		req_t r;
		r           = scrambled_req();
		r.operation = OP_CLEAR;
		send(r);
	endtask

	task automatic unused_item();
		req_t r;
		r           = scrambled_req();
		r.operation = OP_UNUSED;
		send(r);
	endtask

	task automatic random_read();
		if ($urandom_range(99) < 70)
			read_entry(4'($urandom_range(15)), 6'($urandom_range(7)));
		else
			read_entry(4'($urandom_range(15)), 6'($urandom_range(47)));
	endtask

	// A whole word with random characters. Now and then a read slips in between
	// characters, and a few words are broken off by a clear before their end.
	task automatic offer_word(input int len);
		logic [30:0] score;
		bit          cut_short;
		score     = pick_score();
		cut_short = ($urandom_range(19) == 0) && (len > 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(14) == 0)
				random_read();
			if (cut_short && i == len / 2) begin
				clear_table();
				break;
			end
			// The score only counts on the final character; earlier ones carry noise.
			offer_char(16'($urandom_range(65535)),
				(i == len - 1) ? score : 31'($urandom()), i == len - 1);
		end
	endtask

	initial begin
		int pick;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. A read of the empty table first.
		read_entry(4'd0, 6'd0);
		// Largest score and largest character go to the top.
		offer_char(16'hFFFF, '1, 1'b1);
		// An equal score lands behind the existing entry.
		offer_char(16'h0000, '1, 1'b1);
		// A score of zero is never taken in.
		offer_char(16'h1234, '0, 1'b1);
		// A two-character word with a read between its characters, lowest score.
		offer_char(16'h0041, '1, 1'b0);
		read_entry(4'd1, 6'd0);
		offer_char(16'h8000, 31'd1, 1'b1);
		// A middle score pushes the lowest entry down by one.
		offer_char(16'h5555, '0, 1'b0);
		offer_char(16'hAAAA, 31'h4000_0000, 1'b1);
		read_entry(4'd3, 6'd1);
		read_entry(4'd3, 6'd2);
		read_entry(4'd0, 6'd47);
		read_entry(4'd15, 6'd47);
		// The unused operation code must leave everything alone.
		unused_item();
		read_entry(4'd2, 6'd0);
		// A clear in the middle of a word empties the partial word as well.
		offer_char(16'h7E7E, '0, 1'b0);
		clear_table();
		offer_char(16'h00FF, 31'd7, 1'b1);
		read_entry(4'd0, 6'd0);
		read_entry(4'd0, 6'd1);
		clear_table();
		read_entry(4'd0, 6'd0);

		// Random part. It opens with a word of exactly the store's length and
		// one a character too long, then mixes words, reads and clears.
		offer_word(WORD_CHARS_DEF);
		read_entry(4'd0, 6'(WORD_CHARS_DEF - 1));
		offer_word(WORD_CHARS_DEF + 1);
		while (items_sent < ITEM_TARGET) begin
			// At each change of idling pattern the sender waits for all results.
			if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
				drain_results();
				phase          = 1;
				send_idle_pct  = 88;
				recv_stall_pct = 38;
			end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
				drain_results();
				phase          = 2;
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			pick = $urandom_range(99);
			if (pick < 62)
				offer_word(pick_length());
			else if (pick < 90)
				random_read();
			else if (pick < 93)
				clear_table();
			else if (pick < 97)
				// A stray character that becomes the start of whatever word comes next.
				offer_char(16'($urandom_range(65535)), 31'($urandom()), 1'b0);
			else
				unused_item();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/tkw_pkg.sv
rtl/tkw_ram.sv
rtl/top_k_scored_word_insert.sv
bench/word_rank_checker.sv
bench/top_k_scored_word_insert_tb.sv
